FILE: design/lffc_pkg.sv
// ----------------------------------------------------------------------------
// lffc_pkg: shared types, constants and arithmetic helpers
// Holds the register codes, the CORDIC arctangent table, and the saturating
// 48 bit fixed point helpers used by the formation control datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lffc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GAIN_ALONG   = 3'd0;
    localparam logic [2:0] CFG_GAIN_ACROSS  = 3'd1;
    localparam logic [2:0] CFG_DESIRED_SEP  = 3'd2;
    localparam logic [2:0] CFG_DESIRED_BRG  = 3'd3;
    localparam logic [2:0] CFG_OFFSET_DIST  = 3'd4;

    // Reset values of the registers.
    localparam logic [15:0] RST_GAIN        = 16'd256;
    localparam logic [30:0] RST_DIST        = 31'd65536;
    localparam logic [15:0] RST_BEARING     = 16'd0;

    // CORDIC constants (turn angle: 2^31 equals pi, trig values Q2.30).
    localparam int unsigned MAX_CORDIC      = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] TRIG_HI  = 34'sd1073741824;
    localparam logic signed [33:0] TRIG_LO  = -34'sd1073741824;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

    // Divider layout: 32 quotient bits, two per stage.
    localparam int unsigned DIV_BITS        = 2;
    localparam int unsigned DIV_STAGES      = 32 / DIV_BITS;

    localparam logic signed [47:0] MAX48    = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48    = 48'sh8000_0000_0000;

    // Partial products of a 48 bit by 33 bit signed multiplication.
    typedef struct packed {
        logic signed [48:0] hi;
        logic signed [65:0] lo;
    } t_pp;

    function automatic logic signed [32:0] atan_turn(input int unsigned i);
        case (i)
            0:  return 33'sd536870912;
            1:  return 33'sd316933406;
            2:  return 33'sd167458907;
            3:  return 33'sd85004756;
            4:  return 33'sd42667331;
            5:  return 33'sd21354465;
            6:  return 33'sd10679838;
            7:  return 33'sd5340245;
            8:  return 33'sd2670163;
            9:  return 33'sd1335087;
            10: return 33'sd667544;
            11: return 33'sd333772;
            12: return 33'sd166886;
            13: return 33'sd83443;
            14: return 33'sd41722;
            15: return 33'sd20861;
            16: return 33'sd10430;
            17: return 33'sd5215;
            18: return 33'sd2608;
            19: return 33'sd1304;
            20: return 33'sd652;
            21: return 33'sd326;
            22: return 33'sd163;
            23: return 33'sd81;
            default: return 33'sd0;
        endcase
    endfunction

    function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
        logic signed [48:0] s;
        s = a + b;
        if (s[48] != s[47]) begin
            return s[48] ? MIN48 : MAX48;
        end
        return s[47:0];
    endfunction

    function automatic logic signed [47:0] sub48(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
        logic signed [48:0] s;
        s = a - b;
        if (s[48] != s[47]) begin
            return s[48] ? MIN48 : MAX48;
        end
        return s[47:0];
    endfunction

    function automatic logic signed [47:0] neg48(input logic signed [47:0] a);
        return sub48(48'sd0, a);
    endfunction

    // Split the 48 bit operand into a signed upper 16 bits and an unsigned lower 32 bit word.
    function automatic t_pp pp_mul(input logic signed [47:0] a,
                                   input logic signed [32:0] b);
        t_pp p;
        logic signed [15:0] ah;
        logic signed [32:0] al;
        ah   = a[47:32];
        al   = {1'b0, a[31:0]};
        p.hi = ah * b;
        p.lo = al * b;
        return p;
    endfunction

    // Sum the partial products, shift right rounding down, saturate to 48 bits.
    function automatic logic signed [47:0] pp_fin(input t_pp p, input int unsigned sh);
        logic signed [81:0] f;
        logic signed [81:0] s;
        f = $signed({p.hi, 32'd0}) + $signed(p.lo);
        s = f >>> sh;
        if ((&s[81:47]) || !(|s[81:47])) begin
            return s[47:0];
        end
        return s[81] ? MIN48 : MAX48;
    endfunction

    function automatic logic signed [31:0] clamp_trig(input logic signed [33:0] v,
                                                      input logic flip);
        logic signed [33:0] c;
        if (v > TRIG_HI) begin
            c = TRIG_HI;
        end else if (v < TRIG_LO) begin
            c = TRIG_LO;
        end else begin
            c = v;
        end
        if (flip) begin
            c = -c;
        end
        return c[31:0];
    endfunction

    function automatic logic signed [31:0] out32(input logic signed [47:0] v);
        if ((&v[47:31]) || !(|v[47:31])) begin
            return v[31:0];
        end
        return v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

`default_nettype wire

FILE: design/leader_follower_formation_control.sv
// ----------------------------------------------------------------------------
// leader_follower_formation_control: separation-bearing formation law
// Turns leader and follower poses plus leader motion into the follower's
// commanded linear and angular speed, fully pipelined at one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake          | Payload
//  ----------+-----------+--------------------+---------------------------------
//  input     | in        | i_valid / o_stall  | poses, headings, leader speeds
//  output    | out       | o_valid / i_stall  | speed and turn commands
//  config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  The block takes one beat per clock cycle while the output is not stalled. Its
//  stages are a CORDIC load stage, one stage per CORDIC iteration (CORDIC_STEPS
//  capped at 24), a trig clamp stage, eleven multiply/combine stages, a divider setup
//  stage, restoring divider stages that retire two quotient bits each, and an output register.
//  Reset clears all valid bits and loads the configuration defaults.
//  When an output beat waits on i_stall the whole pipeline holds; nothing is
//  lost or repeated, and o_stall is raised toward the source meanwhile.
//
`default_nettype none

module leader_follower_formation_control
    import lffc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_follower_x,
    input  wire logic signed [31:0] i_leader_x,
    input  wire logic signed [31:0] i_follower_y,
    input  wire logic signed [31:0] i_leader_y,
    input  wire logic signed [15:0] i_leader_heading,
    input  wire logic signed [15:0] i_follower_heading,
    input  wire logic signed [31:0] i_leader_turn_rate,
    input  wire logic signed [31:0] i_leader_speed,

    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_follower_speed_cmd,
    output logic signed [31:0]      o_follower_turn_cmd,

    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data
);

    // Number of CORDIC iterations actually built.
    localparam int NC  = (CORDIC_STEPS < MAX_CORDIC) ? CORDIC_STEPS : MAX_CORDIC;
    // Stage count: CORDIC load and iterations, trig clamp, eleven datapath
    // stages, divider setup and iterations, output register.
    localparam int NST = NC + 31;

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while the pipeline
    // is empty (the block does not enforce this), so every stage reads them directly.
    // ------------------------------------------------------------------
    logic [15:0] r_gain_along;
    logic [15:0] r_gain_across;
    logic [30:0] r_desired_sep;
    logic [15:0] r_desired_brg;
    logic [30:0] r_offset_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_along  <= RST_GAIN;
            r_gain_across <= RST_GAIN;
            r_desired_sep <= RST_DIST;
            r_desired_brg <= RST_BEARING;
            r_offset_dist <= RST_DIST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_ALONG:  r_gain_along  <= i_cfg_data[15:0];
                CFG_GAIN_ACROSS: r_gain_across <= i_cfg_data[15:0];
                CFG_DESIRED_SEP: r_desired_sep <= i_cfg_data;
                CFG_DESIRED_BRG: r_desired_brg <= i_cfg_data[15:0];
                CFG_OFFSET_DIST: r_offset_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero offset is used as the smallest step in the divider only.
    logic [30:0] den;
    assign den = (r_offset_dist == 31'd0) ? 31'd1 : r_offset_dist;

    // ------------------------------------------------------------------
    // Pipeline control: a single enable; valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic           en;

    assign o_valid = r_vld[NST-1];
    assign o_stall = r_vld[NST-1] & i_stall;
    assign en      = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: four lanes (follower heading, leader heading, desired
    // bearing, heading error), one iteration per stage. Side data rides
    // along in the same stages.
    // ------------------------------------------------------------------
    logic signed [33:0] r_cx   [0:NC][0:3];
    logic signed [33:0] r_cy   [0:NC][0:3];
    logic signed [32:0] r_cz   [0:NC][0:3];
    logic               r_flip [0:NC][0:3];
    logic signed [32:0] r_cdx  [0:NC];
    logic signed [32:0] r_cdy  [0:NC];
    logic signed [31:0] r_cwl  [0:NC];
    logic signed [31:0] r_cvl  [0:NC];

    logic [15:0] lane_ang [0:3];
    assign lane_ang[0] = i_follower_heading;
    assign lane_ang[1] = i_leader_heading;
    assign lane_ang[2] = r_desired_brg;
    assign lane_ang[3] = i_follower_heading - i_leader_heading;

    for (genvar l = 0; l < 4; l++) begin : g_load
        logic signed [32:0] n_z;
        logic               n_flip;
        logic signed [32:0] z0;

        // Angles beyond a quarter turn are folded by half a turn.
        always_comb begin
            z0     = $signed({lane_ang[l][15], lane_ang[l], 16'd0});
            n_flip = 1'b0;
            n_z    = z0;
            if (z0 > QUARTER_TURN) begin
                n_z    = z0 - HALF_TURN;
                n_flip = 1'b1;
            end else if (z0 < -QUARTER_TURN) begin
                n_z    = z0 + HALF_TURN;
                n_flip = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[0][l]   <= CORDIC_GAIN;
                r_cy[0][l]   <= 34'sd0;
                r_cz[0][l]   <= n_z;
                r_flip[0][l] <= n_flip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cdx[0] <= {i_leader_x[31], i_leader_x} - {i_follower_x[31], i_follower_x};
            r_cdy[0] <= {i_leader_y[31], i_leader_y} - {i_follower_y[31], i_follower_y};
            r_cwl[0] <= i_leader_turn_rate;
            r_cvl[0] <= i_leader_speed;
        end
    end

    for (genvar k = 1; k <= NC; k++) begin : g_cordic
        for (genvar l = 0; l < 4; l++) begin : g_lane
            logic signed [33:0] n_x;
            logic signed [33:0] n_y;
            logic signed [32:0] n_z;

            always_comb begin
                if (!r_cz[k-1][l][32]) begin
                    n_x = r_cx[k-1][l] - (r_cy[k-1][l] >>> (k - 1));
                    n_y = r_cy[k-1][l] + (r_cx[k-1][l] >>> (k - 1));
                    n_z = r_cz[k-1][l] - atan_turn(k - 1);
                end else begin
                    n_x = r_cx[k-1][l] + (r_cy[k-1][l] >>> (k - 1));
                    n_y = r_cy[k-1][l] - (r_cx[k-1][l] >>> (k - 1));
                    n_z = r_cz[k-1][l] + atan_turn(k - 1);
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cx[k][l]   <= n_x;
                    r_cy[k][l]   <= n_y;
                    r_cz[k][l]   <= n_z;
                    r_flip[k][l] <= r_flip[k-1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cdx[k] <= r_cdx[k-1];
                r_cdy[k] <= r_cdy[k-1];
                r_cwl[k] <= r_cwl[k-1];
                r_cvl[k] <= r_cvl[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, stage by stage.
    // ------------------------------------------------------------------
    // Trig clamp stage.
    logic signed [31:0] r_tc [0:3];
    logic signed [31:0] r_ts [0:3];
    logic signed [32:0] r_t_dx, r_t_dy;
    logic signed [31:0] r_t_wl, r_t_vl;
    // Offset and desired position products.
    t_pp                r_a_pc, r_a_ps, r_a_lc, r_a_ls;
    logic signed [32:0] r_a_dx, r_a_dy;
    logic signed [31:0] r_a_wl, r_a_vl, r_a_cl, r_a_sl, r_a_ce, r_a_se;
    // Control point offset and desired position.
    logic signed [47:0] r_b_px, r_b_py, r_b_lxd, r_b_lyd;
    logic signed [31:0] r_b_wl, r_b_vl, r_b_cl, r_b_sl, r_b_ce, r_b_se;
    // Rotation into the leader frame: products.
    t_pp                r_c_p1, r_c_p2, r_c_p3, r_c_p4;
    logic signed [47:0] r_c_lxd, r_c_lyd;
    logic signed [31:0] r_c_wl, r_c_vl, r_c_ce, r_c_se;
    // Rotation into the leader frame: scaled terms.
    logic signed [47:0] r_d_t1, r_d_t2, r_d_t3, r_d_t4, r_d_lxd, r_d_lyd;
    logic signed [31:0] r_d_wl, r_d_vl, r_d_ce, r_d_se;
    // Separation errors.
    logic signed [47:0] r_e_ex, r_e_ey, r_e_lxd, r_e_lyd;
    logic signed [31:0] r_e_wl, r_e_vl, r_e_ce, r_e_se;
    // Gain and feedforward products.
    t_pp                r_f_p1, r_f_p2, r_f_p3, r_f_p4, r_f_p5, r_f_p6;
    logic signed [31:0] r_f_vl, r_f_ce, r_f_se;
    // Gain and feedforward terms.
    logic signed [47:0] r_g_u1, r_g_u2, r_g_u3, r_g_u4, r_g_u5, r_g_u6;
    logic signed [31:0] r_g_vl, r_g_ce, r_g_se;
    // Frame-aligned commands before the heading error rotation.
    logic signed [47:0] r_h_a, r_h_b, r_h_na;
    logic signed [31:0] r_h_ce, r_h_se;
    // Heading error rotation: products and scaled terms.
    t_pp                r_i_p1, r_i_p2, r_i_p3, r_i_p4;
    logic signed [47:0] r_j_w1, r_j_w2, r_j_w3, r_j_w4;
    // Speed result and turn numerator magnitude.
    logic signed [31:0] r_k_v32;
    logic [47:0]        r_k_mag;
    logic               r_k_neg;

    logic signed [47:0] n_lx, n_ly, n_f1, n_a, n_b, n_v, n_num;
    logic signed [47:0] k1_ext, k2_ext;

    always_comb begin
        n_lx  = sub48(neg48(r_d_t1), r_d_t2);
        n_ly  = sub48(r_d_t3, r_d_t4);
        n_f1  = add48(neg48(r_g_u3), {{16{r_g_vl[31]}}, r_g_vl});
        n_a   = add48(add48(r_g_u1, r_g_u2), n_f1);
        n_b   = sub48(add48(neg48(r_g_u4), r_g_u5), r_g_u6);
        n_v   = sub48(r_j_w1, r_j_w2);
        n_num = sub48(r_j_w3, r_j_w4);
    end

    assign k1_ext = {32'd0, r_gain_along};
    assign k2_ext = {32'd0, r_gain_across};

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Trig clamp and fold-back.
            for (int l = 0; l < 4; l++) begin
                r_tc[l] <= clamp_trig(r_cx[NC][l], r_flip[NC][l]);
                r_ts[l] <= clamp_trig(r_cy[NC][l], r_flip[NC][l]);
            end
            r_t_dx <= r_cdx[NC];
            r_t_dy <= r_cdy[NC];
            r_t_wl <= r_cwl[NC];
            r_t_vl <= r_cvl[NC];

            // Offset d*cos/sin of follower heading, ld*cos/sin of bearing.
            r_a_pc <= pp_mul({17'd0, r_offset_dist}, {r_tc[0][31], r_tc[0]});
            r_a_ps <= pp_mul({17'd0, r_offset_dist}, {r_ts[0][31], r_ts[0]});
            r_a_lc <= pp_mul({17'd0, r_desired_sep}, {r_tc[2][31], r_tc[2]});
            r_a_ls <= pp_mul({17'd0, r_desired_sep}, {r_ts[2][31], r_ts[2]});
            r_a_dx <= r_t_dx;
            r_a_dy <= r_t_dy;
            r_a_wl <= r_t_wl;
            r_a_vl <= r_t_vl;
            r_a_cl <= r_tc[1];
            r_a_sl <= r_ts[1];
            r_a_ce <= r_tc[3];
            r_a_se <= r_ts[3];

            r_b_px  <= sub48({{15{r_a_dx[32]}}, r_a_dx}, pp_fin(r_a_pc, 30));
            r_b_py  <= sub48({{15{r_a_dy[32]}}, r_a_dy}, pp_fin(r_a_ps, 30));
            r_b_lxd <= pp_fin(r_a_lc, 30);
            r_b_lyd <= pp_fin(r_a_ls, 30);
            r_b_wl  <= r_a_wl;
            r_b_vl  <= r_a_vl;
            r_b_cl  <= r_a_cl;
            r_b_sl  <= r_a_sl;
            r_b_ce  <= r_a_ce;
            r_b_se  <= r_a_se;

            r_c_p1  <= pp_mul(r_b_px, {r_b_cl[31], r_b_cl});
            r_c_p2  <= pp_mul(r_b_py, {r_b_sl[31], r_b_sl});
            r_c_p3  <= pp_mul(r_b_px, {r_b_sl[31], r_b_sl});
            r_c_p4  <= pp_mul(r_b_py, {r_b_cl[31], r_b_cl});
            r_c_lxd <= r_b_lxd;
            r_c_lyd <= r_b_lyd;
            r_c_wl  <= r_b_wl;
            r_c_vl  <= r_b_vl;
            r_c_ce  <= r_b_ce;
            r_c_se  <= r_b_se;

            r_d_t1  <= pp_fin(r_c_p1, 30);
            r_d_t2  <= pp_fin(r_c_p2, 30);
            r_d_t3  <= pp_fin(r_c_p3, 30);
            r_d_t4  <= pp_fin(r_c_p4, 30);
            r_d_lxd <= r_c_lxd;
            r_d_lyd <= r_c_lyd;
            r_d_wl  <= r_c_wl;
            r_d_vl  <= r_c_vl;
            r_d_ce  <= r_c_ce;
            r_d_se  <= r_c_se;

            r_e_ex  <= sub48(r_d_lxd, n_lx);
            r_e_ey  <= sub48(r_d_lyd, n_ly);
            r_e_lxd <= r_d_lxd;
            r_e_lyd <= r_d_lyd;
            r_e_wl  <= r_d_wl;
            r_e_vl  <= r_d_vl;
            r_e_ce  <= r_d_ce;
            r_e_se  <= r_d_se;

            r_f_p1 <= pp_mul(r_e_ex, k1_ext[32:0]);
            r_f_p2 <= pp_mul(r_e_ey, {r_e_wl[31], r_e_wl});
            r_f_p3 <= pp_mul(r_e_lyd, {r_e_wl[31], r_e_wl});
            r_f_p4 <= pp_mul(r_e_ey, k2_ext[32:0]);
            r_f_p5 <= pp_mul(r_e_ex, {r_e_wl[31], r_e_wl});
            r_f_p6 <= pp_mul(r_e_lxd, {r_e_wl[31], r_e_wl});
            r_f_vl <= r_e_vl;
            r_f_ce <= r_e_ce;
            r_f_se <= r_e_se;

            r_g_u1 <= pp_fin(r_f_p1, 8);
            r_g_u2 <= pp_fin(r_f_p2, 16);
            r_g_u3 <= pp_fin(r_f_p3, 16);
            r_g_u4 <= pp_fin(r_f_p4, 8);
            r_g_u5 <= pp_fin(r_f_p5, 16);
            r_g_u6 <= pp_fin(r_f_p6, 16);
            r_g_vl <= r_f_vl;
            r_g_ce <= r_f_ce;
            r_g_se <= r_f_se;

            r_h_a  <= n_a;
            r_h_b  <= n_b;
            r_h_na <= neg48(n_a);
            r_h_ce <= r_g_ce;
            r_h_se <= r_g_se;

            r_i_p1 <= pp_mul(r_h_a,  {r_h_ce[31], r_h_ce});
            r_i_p2 <= pp_mul(r_h_b,  {r_h_se[31], r_h_se});
            r_i_p3 <= pp_mul(r_h_na, {r_h_se[31], r_h_se});
            r_i_p4 <= pp_mul(r_h_b,  {r_h_ce[31], r_h_ce});

            r_j_w1 <= pp_fin(r_i_p1, 30);
            r_j_w2 <= pp_fin(r_i_p2, 30);
            r_j_w3 <= pp_fin(r_i_p3, 30);
            r_j_w4 <= pp_fin(r_i_p4, 30);

            r_k_v32 <= out32(n_v);
            r_k_neg <= n_num[47];
            r_k_mag <= n_num[47] ? 48'd0 - n_num : n_num;
        end
    end

    // ------------------------------------------------------------------
    // Turn divider: (mag * 65536) / den as a restoring divider. If the top
    // half already reaches the divisor the quotient saturates anyway, so
    // only 32 quotient bits are developed.
    // ------------------------------------------------------------------
    logic [30:0] r_dr   [0:DIV_STAGES];
    logic [31:0] r_dn   [0:DIV_STAGES];
    logic [31:0] r_dq   [0:DIV_STAGES];
    logic        r_dovf [0:DIV_STAGES];
    logic        r_dneg [0:DIV_STAGES];
    logic [31:0] r_dv   [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dovf[0] <= (r_k_mag[47:16] >= {1'b0, den});
            r_dr[0]   <= r_k_mag[46:16];
            r_dn[0]   <= {r_k_mag[15:0], 16'd0};
            r_dq[0]   <= 32'd0;
            r_dneg[0] <= r_k_neg;
            r_dv[0]   <= r_k_v32;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        logic [30:0] n_r;
        logic [31:0] n_n;
        logic [31:0] n_q;

        always_comb begin
            logic [31:0] t;
            n_r = r_dr[j-1];
            n_n = r_dn[j-1];
            n_q = r_dq[j-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                t   = {n_r, n_n[31]};
                n_n = {n_n[30:0], 1'b0};
                if (t >= {1'b0, den}) begin
                    t   = t - {1'b0, den};
                    n_q = {n_q[30:0], 1'b1};
                end else begin
                    n_q = {n_q[30:0], 1'b0};
                end
                n_r = t[30:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dr[j]   <= n_r;
                r_dn[j]   <= n_n;
                r_dq[j]   <= n_q;
                r_dovf[j] <= r_dovf[j-1];
                r_dneg[j] <= r_dneg[j-1];
                r_dv[j]   <= r_dv[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. A quotient of 2^31 or more saturates: the most
    // negative value on the negative side, the largest positive otherwise.
    // ------------------------------------------------------------------
    logic signed [31:0] r_o_speed;
    logic signed [31:0] r_o_turn;
    logic signed [31:0] n_turn;
    logic [31:0]        q_fin;

    always_comb begin
        q_fin = r_dq[DIV_STAGES];
        if (r_dovf[DIV_STAGES] || q_fin[31]) begin
            n_turn = r_dneg[DIV_STAGES] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (r_dneg[DIV_STAGES]) begin
            n_turn = 32'sd0 - $signed(q_fin);
        end else begin
            n_turn = $signed(q_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_speed <= r_dv[DIV_STAGES];
            r_o_turn  <= n_turn;
        end
    end

    assign o_follower_speed_cmd = r_o_speed;
    assign o_follower_turn_cmd  = r_o_turn;

endmodule

`default_nettype wire
